// ===== hw/rtl/crc15_pkg.sv =====
// shared constants for the bytewise crc-15 unit
package crc15_pkg;

    localparam int REM_W  = 16;
    localparam int CRC_W  = 15;
    localparam int BYTE_W = 8;

    localparam logic [REM_W-1:0] POLY_RESET = 16'hC599;
    localparam logic [REM_W-1:0] TOP_BIT    = 16'h8000;
    localparam logic [REM_W-1:0] CRC_MASK   = 16'h7FFF;

    typedef logic [REM_W-1:0] rem_t;
    typedef logic [CRC_W-1:0] crc_t;
    typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== hw/rtl/crc15_bytewise_lsb_first_unit.sv =====
// top level of the bytewise lsb-first crc-15 unit
// One byte per transfer, one running CRC result per byte, sustained rate of one
// byte per clock while out_stall is low. A byte is captured in an input register,
// then the eight bit steps are done combinationally into the remainder register,
// which also drives crc_value. start_of_message clears the remainder before its
// byte. The polynomial register (reset 0xC599) is written with cfg_we/cfg_wdata;
// the user must write it only while the unit is idle, the unit does not enforce it.
module crc15_bytewise_lsb_first_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  crc15_pkg::byte_t  data_byte,
    input  logic              start_of_message,
    output logic              out_valid,
    input  logic              out_stall,
    output crc15_pkg::crc_t   crc_value,
    input  logic              cfg_we,
    input  crc15_pkg::rem_t   cfg_wdata
);
    import crc15_pkg::*;

    rem_t  poly_reg;
    rem_t  remainder_reg;
    rem_t  remainder_next;
    logic  out_valid_reg;
    logic  s1_valid_reg;
    byte_t s1_byte_reg;
    logic  s1_start_reg;
    logic  out_free;
    logic  s1_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_take  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    crc15_byte_step u_step (
        .rem     (remainder_reg),
        .data    (s1_byte_reg),
        .clear   (s1_start_reg),
        .poly    (poly_reg),
        .rem_out (remainder_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= POLY_RESET;
            remainder_reg <= '0;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                poly_reg <= cfg_wdata;
            end
            if (s1_take)
            begin
                remainder_reg <= remainder_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // input register refills whenever it is empty or draining
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg  <= data_byte;
            s1_start_reg <= start_of_message;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = crc_t'(remainder_reg & CRC_MASK);

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_free_moves_on : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("captured byte not moved to result");

    a_start_zero_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_take && s1_start_reg && s1_byte_reg == '0) |=> remainder_reg == '0)
        else $error("start with zero byte left nonzero remainder");

    a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(remainder_reg))
        else $error("remainder changed while result stalled");

endmodule

// ===== hw/rtl/crc15_byte_step.sv =====
// eight lsb-first shift/xor steps of the crc remainder for one byte
module crc15_byte_step (
    input  crc15_pkg::rem_t  rem,
    input  crc15_pkg::byte_t data,
    input  logic             clear,
    input  crc15_pkg::rem_t  poly,
    output crc15_pkg::rem_t  rem_out
);
    import crc15_pkg::*;

    rem_t acc;

    always_comb
    begin
        acc = clear ? '0 : rem;
        for (int k = 0; k < BYTE_W; k++)
        begin
            acc = {acc[REM_W-2:0], data[k]};
            if ((acc & TOP_BIT) != '0)
            begin
                acc = acc ^ poly;
            end
        end
        rem_out = acc;
    end

endmodule

// ===== verif/crc15_bytewise_lsb_first_unit_tb.sv =====
// testbench for the bytewise lsb-first crc-15 unit: random and directed bytes against a predictor
module crc15_bytewise_lsb_first_unit_tb;

    import crc15_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int RUN_LIMIT     = 1000000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    byte_t data_byte;
    logic  start_of_message;
    logic  out_valid;
    logic  out_stall;
    crc_t  crc_value;
    logic  cfg_we;
    rem_t  cfg_wdata;

    // predictor state
    rem_t  remainder_model;
    rem_t  poly_model;
    crc_t  crc_q[$];

    int    gap_max;
    int    stall_max;
    int    hold_cycles;
    int    mismatches;
    int    bytes_sent;
    int    results_seen;
    int    poly_writes;
    int    in_stall_cycles;
    crc_t  want_crc;

    crc15_bytewise_lsb_first_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .start_of_message (start_of_message),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .crc_value        (crc_value),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // eight shift steps, bit 0 of the byte first, no augmenting zeros
    function automatic rem_t advance_remainder(rem_t rem, byte_t b, rem_t poly);
        rem_t r;
        r = rem;
        for (int k = 0; k < BYTE_W; k++)
        begin
            r = {r[REM_W-2:0], b[k]};
            if ((r & TOP_BIT) != '0)
                r = r ^ poly;
        end
        return r;
    endfunction

    task automatic send_byte(input byte_t b, input logic som);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        data_byte        <= b;
        start_of_message <= som;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        if (som)
            remainder_model = '0;
        remainder_model = advance_remainder(remainder_model, b, poly_model);
        crc_q.push_back(crc_t'(remainder_model & CRC_MASK));
        bytes_sent++;
    endtask

    // lowers valid in the step of the last transfer, then waits for every result
    task automatic drain();
        in_valid <= 1'b0;
        while (crc_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_polynomial(input rem_t p);
        cfg_wdata <= p;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        poly_model = p;
        poly_writes++;
    endtask

    task automatic send_message(input int len, input bit noisy);
        byte_t b;
        logic  som;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(9, 0))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = byte_t'($urandom_range(255, 0));
            endcase
            som = noisy ? logic'($urandom_range(1, 0)) : (i == 0);
            send_byte(b, som);
        end
    endtask

    task automatic test_reset_defaults();
        // no start flag on the first byte: continues from the zero remainder
        gap_max   = 3;
        stall_max = 3;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        drain();
    endtask

    task automatic test_polynomial_extremes();
        rem_t polys[5];
        polys = '{16'h0000, 16'hFFFF, 16'h4599, 16'h7FFF, POLY_RESET};
        // 4599 and 7fff lack the top bit, so it survives the xor until shifted out
        foreach (polys[i])
        begin
            write_polynomial(polys[i]);
            send_byte(8'hFF, 1'b1);
            send_byte(8'h00, 1'b0);
            send_byte(8'h55, 1'b0);
            drain();
        end
    endtask

    task automatic run_random_phase(input rem_t poly, input int gmax, input int smax,
                                    input int count);
        int target;
        write_polynomial(poly);
        gap_max   = gmax;
        stall_max = smax;
        target    = bytes_sent + count;
        while (bytes_sent < target)
            send_message($urandom_range(12, 1), $urandom_range(7, 0) == 0);
        drain();
    endtask

    task automatic test_random_traffic();
        run_random_phase(rem_t'($urandom_range(16'hFFFF, 0)) | TOP_BIT, 0, 0, 115);
        run_random_phase(rem_t'($urandom_range(16'hFFFF, 0)), 18, 0, 115);
        run_random_phase(POLY_RESET, 0, 18, 115);
        run_random_phase(rem_t'($urandom_range(16'hFFFF, 0)) & CRC_MASK, 18, 18, 115);
        run_random_phase(rem_t'($urandom_range(16'hFFFF, 0)), 18, 18, 115);
    endtask

    task automatic test_output_backpressure();
        gap_max     = 0;
        stall_max   = 0;
        hold_cycles = 150;
        send_message(40, 1'b0);
        // sender pauses mid-message until every result is back
        in_valid <= 1'b0;
        while (crc_q.size() != 0)
            @(posedge clk);
        gap_max   = 4;
        stall_max = 4;
        for (int i = 0; i < 20; i++)
            send_byte(byte_t'($urandom_range(255, 0)), 1'b0);
        drain();
    endtask

    // receiver: random hold-off per result, or one long hold when requested
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n           = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = $urandom_range(stall_max, 0);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            in_stall_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (crc_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result crc_value=%h", crc_value);
                mismatches++;
            end
            else
            begin
                want_crc = crc_q.pop_front();
                if (crc_value !== want_crc)
                begin
                    if (mismatches < 10)
                        $display("crc_value mismatch: expected %h, got %h",
                                 want_crc, crc_value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        gap_max          = 0;
        stall_max        = 0;
        hold_cycles      = 0;
        mismatches       = 0;
        bytes_sent       = 0;
        results_seen     = 0;
        poly_writes      = 0;
        in_stall_cycles  = 0;
        remainder_model  = '0;
        poly_model       = POLY_RESET;
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        data_byte        <= '0;
        start_of_message <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_polynomial_extremes();
        test_random_traffic();
        test_output_backpressure();

        drain();
        mismatches += crc_q.size();
        $display("covered %0d bytes and %0d results under %0d polynomial writes",
                 bytes_sent, results_seen, poly_writes);
        $display("input held off for %0d cycles while the output was blocked",
                 in_stall_cycles);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
